FILE: rtl/tsq_pkg.sv
package tsq_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int PTR_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;

    localparam logic [1:0] CMD_PUSH = 2'd0;
    localparam logic [1:0] CMD_POP  = 2'd1;
    localparam logic [1:0] CMD_PEEK = 2'd2;

    localparam logic signed [DATA_W-1:0] FAIL_VALUE = 32'sd10;

    typedef struct packed {
        logic [1:0]               command;
        logic signed [DATA_W-1:0] push_value;
    } tsq_req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic                     failed;
        logic                     empty_res;
    } tsq_res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_XFER_RD,
        ST_XFER_WR,
        ST_READ,
        ST_DELIVER
    } tsq_state_t;

endpackage

FILE: rtl/two_stack_queue.sv
// Channel   Handshake          Payload    Notes
// request   start & !busy      command,   taken at the clock edge
//                              push_value
// result    done (one cycle)   read_value,  one result per item,
//                              failed,      cannot be held off
//                              empty_res
//
// Push, an unused command and pop/peek on an empty queue: result in the cycle
// after the item is taken. Pop/peek with outbound entries: via ST_DELIVER.
// Pop/peek that must refill the outbound stack from n inbound entries: per
// entry ST_XFER_RD, then ST_XFER_WR, as the inbound memory's single read port
// moves one entry at a time (read, then write); then ST_READ and ST_DELIVER.
// Reset clears counts and control only; the stack memories need no clearing.
// busy is high while an item is in work; no result is ever stalled.
module two_stack_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  tsq_pkg::tsq_req_t request,
    output logic              busy,
    output logic              done,
    output tsq_pkg::tsq_res_t result
);
    import tsq_pkg::*;

    tsq_state_t state_reg, state_next;

    logic [CNT_W-1:0] in_cnt_reg, in_cnt_next;
    logic [CNT_W-1:0] out_cnt_reg, out_cnt_next;

    logic        done_reg, done_next;
    tsq_res_t    res_reg, res_next;
    tsq_req_t    req_reg;

    logic signed [DATA_W-1:0] in_mem  [STACK_DEPTH];
    logic signed [DATA_W-1:0] out_mem [STACK_DEPTH];
    logic signed [DATA_W-1:0] in_rd_reg;
    logic signed [DATA_W-1:0] out_rd_reg;

    logic             in_we, out_we;
    logic [CNT_W-1:0] in_top, out_top;
    logic             accept;

    assign accept  = start && (state_reg == ST_IDLE);
    assign in_top  = in_cnt_reg - CNT_W'(1);
    assign out_top = out_cnt_reg - CNT_W'(1);

    // Stack memories: one write and one registered read per cycle each
    always_ff @(posedge clk)
    begin
        if (in_we)
        begin
            in_mem[in_cnt_reg[PTR_W-1:0]] <= request.push_value;
        end
        in_rd_reg <= in_mem[in_top[PTR_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (out_we)
        begin
            out_mem[out_cnt_reg[PTR_W-1:0]] <= in_rd_reg;
        end
        out_rd_reg <= out_mem[out_top[PTR_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= request;
        end
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            in_cnt_reg  <= '0;
            out_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            in_cnt_reg  <= in_cnt_next;
            out_cnt_reg <= out_cnt_next;
            done_reg    <= done_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (request.command) inside
                        CMD_POP, CMD_PEEK:
                        begin
                            if (out_cnt_reg != '0)
                            begin
                                state_next = ST_DELIVER;
                            end
                            else if (in_cnt_reg != '0)
                            begin
                                state_next = ST_XFER_RD;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_XFER_RD:
            begin
                state_next = ST_XFER_WR;
            end
            ST_XFER_WR:
            begin
                // count already advanced past the entry being written
                state_next = (in_cnt_reg == '0) ? ST_READ : ST_XFER_RD;
            end
            ST_READ:
            begin
                state_next = ST_DELIVER;
            end
            ST_DELIVER:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_cnt_next         = in_cnt_reg;
        out_cnt_next        = out_cnt_reg;
        in_we               = 1'b0;
        out_we              = 1'b0;
        done_next           = 1'b0;
        res_next.read_value = '0;
        res_next.failed     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (request.command) inside
                        CMD_PUSH:
                        begin
                            done_next = 1'b1;
                            if (in_cnt_reg == CNT_W'(STACK_DEPTH))
                            begin
                                res_next.failed = 1'b1;
                            end
                            else
                            begin
                                in_we       = 1'b1;
                                in_cnt_next = in_cnt_reg + CNT_W'(1);
                            end
                        end
                        CMD_POP, CMD_PEEK:
                        begin
                            if (out_cnt_reg == '0 && in_cnt_reg == '0)
                            begin
                                done_next           = 1'b1;
                                res_next.failed     = 1'b1;
                                res_next.read_value = FAIL_VALUE;
                            end
                        end
                        default:
                        begin
                            done_next       = 1'b1;
                            res_next.failed = 1'b1;
                        end
                    endcase
                end
            end
            ST_XFER_RD:
            begin
                in_cnt_next = in_top;
            end
            ST_XFER_WR:
            begin
                out_we       = 1'b1;
                out_cnt_next = out_cnt_reg + CNT_W'(1);
            end
            ST_READ:
            begin
                done_next = 1'b0;
            end
            ST_DELIVER:
            begin
                done_next           = 1'b1;
                res_next.read_value = out_rd_reg;
                if (req_reg.command == CMD_POP)
                begin
                    out_cnt_next = out_top;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
        res_next.empty_res = (in_cnt_next == '0) && (out_cnt_next == '0);
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    import tsq_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1050;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 2 * STACK_DEPTH + 8;

    typedef struct {
        tsq_req_t req;
        int       gap_pct;
    } pending_item_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    tsq_req_t request = '0;
    logic     busy;
    logic     done;
    tsq_res_t result;

    pending_item_t pending_items[$];
    tsq_res_t      expected_results[$];
    int            mismatch_count = 0;
    int            cycle_count = 0;
    bit            item_taken = 1'b0;

    // Queue state as the block should hold it
    logic signed [DATA_W-1:0] inbound_mem[STACK_DEPTH];
    logic signed [DATA_W-1:0] outbound_mem[STACK_DEPTH];
    int                       inbound_cnt = 0;
    int                       outbound_cnt = 0;

    two_stack_queue dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic tsq_res_t queue_step(input tsq_req_t req);
        tsq_res_t res;
        res = '0;
        case (req.command)
            CMD_PUSH:
            begin
                if (inbound_cnt >= STACK_DEPTH)
                begin
                    res.failed = 1'b1;
                end
                else
                begin
                    inbound_mem[inbound_cnt] = req.push_value;
                    inbound_cnt++;
                end
            end
            CMD_POP, CMD_PEEK:
            begin
                // refill reverses the inbound order, oldest ends on top
                if (outbound_cnt == 0)
                begin
                    while (inbound_cnt > 0)
                    begin
                        inbound_cnt--;
                        outbound_mem[outbound_cnt] = inbound_mem[inbound_cnt];
                        outbound_cnt++;
                    end
                end
                if (outbound_cnt == 0)
                begin
                    res.read_value = FAIL_VALUE;
                    res.failed     = 1'b1;
                end
                else
                begin
                    res.read_value = outbound_mem[outbound_cnt - 1];
                    if (req.command == CMD_POP)
                        outbound_cnt--;
                end
            end
            default:
            begin
                res.failed = 1'b1;
            end
        endcase
        res.empty_res = (inbound_cnt == 0) && (outbound_cnt == 0);
        return res;
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        logic [DATA_W-1:0] v;
        case ($urandom_range(3))
            0:
            begin
                case ($urandom_range(4))
                    0:       v = 32'h8000_0000;
                    1:       v = 32'h7FFF_FFFF;
                    2:       v = 32'hFFFF_FFFF;
                    3:       v = 32'd0;
                    default: v = FAIL_VALUE;
                endcase
            end
            1:       v = $urandom_range(64) - 32;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic add_item(input logic [1:0] cmd, input logic [DATA_W-1:0] v,
                            input int gap);
        pending_item_t it;
        it.req.command    = cmd;
        it.req.push_value = v;
        it.gap_pct        = gap;
        pending_items.push_back(it);
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Result checker and item capture
    always @(posedge clk)
    begin
        tsq_res_t exp_res;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result with nothing expected: value %0d failed %0b empty %0b",
                             $time, result.read_value, result.failed, result.empty_res);
                    mismatch_count++;
                end
                else
                begin
                    exp_res = expected_results.pop_front();
                    if (result.read_value !== exp_res.read_value ||
                        result.failed !== exp_res.failed ||
                        result.empty_res !== exp_res.empty_res)
                    begin
                        $display("%0t: expected value %0d failed %0b empty %0b, got value %0d failed %0b empty %0b",
                                 $time, exp_res.read_value, exp_res.failed, exp_res.empty_res,
                                 result.read_value, result.failed, result.empty_res);
                        mismatch_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                expected_results.push_back(queue_step(request));
                item_taken = 1'b1;
            end
        end
    end

    // Item driver: hold an item until taken, idle at random between items
    always @(negedge clk)
    begin
        pending_item_t nxt;
        if (rst_n && (item_taken || !start))
        begin
            item_taken = 1'b0;
            if (pending_items.size() > 0 && $urandom_range(99) >= pending_items[0].gap_pct)
            begin
                nxt = pending_items.pop_front();
                start   <= 1'b1;
                request <= nxt.req;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("tb_top: errors");
        $finish;
    end

    initial
    begin
        int phase_gap[4];
        int target;
        int n;
        phase_gap = '{0, 83, 0, 22};

        // empty queue, unused code, fill inbound past full, then peek and pop
        add_item(CMD_POP, 32'd5, 0);
        add_item(CMD_PEEK, 32'hFFFF_FFFF, 0);
        add_item(CMD_UNUSED, 32'h1234_5678, 0);
        add_item(CMD_PUSH, 32'h8000_0000, 0);
        add_item(CMD_PUSH, 32'h7FFF_FFFF, 0);
        add_item(CMD_PUSH, 32'hFFFF_FFFF, 0);
        add_item(CMD_PUSH, 32'd0, 0);
        add_item(CMD_PUSH, FAIL_VALUE, 0);
        for (int i = 5; i < STACK_DEPTH; i++)
            add_item(CMD_PUSH, $urandom, 0);
        add_item(CMD_PUSH, 32'hDEAD_BEEF, 0);
        add_item(CMD_PEEK, 32'd0, 0);
        add_item(CMD_POP, 32'd0, 0);
        add_item(CMD_PUSH, 32'hA5A5_5A5A, 0);
        add_item(CMD_UNUSED, 32'd0, 0);
        add_item(CMD_POP, 32'd0, 0);

        target = pending_items.size();
        for (int p = 0; p < 4; p++)
        begin
            target += RANDOM_ITEMS / 4;
            while (pending_items.size() < target)
            begin
                if ($urandom_range(99) < 60)
                begin
                    // burst of pushes, then reads (mostly pops), sometimes past empty
                    n = $urandom_range(STACK_DEPTH + 2, 1);
                    for (int i = 0; i < n; i++)
                        add_item(CMD_PUSH, pick_value(), phase_gap[p]);
                    n = $urandom_range(n + 2, 1);
                    for (int i = 0; i < n; i++)
                        add_item(($urandom_range(3) == 0) ? CMD_PEEK : CMD_POP,
                                 $urandom, phase_gap[p]);
                end
                else
                begin
                    case ($urandom_range(19))
                        0:                  add_item(CMD_UNUSED, $urandom, phase_gap[p]);
                        1, 2, 3:            add_item(CMD_PEEK, $urandom, phase_gap[p]);
                        4, 5, 6, 7, 8, 9:   add_item(CMD_POP, $urandom, phase_gap[p]);
                        default:            add_item(CMD_PUSH, pick_value(), phase_gap[p]);
                    endcase
                end
            end
        end

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() > 0 || start)
            @(posedge clk);
        while (expected_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/tsq_pkg.sv
rtl/two_stack_queue.sv
tb/tb_top.sv
